@@ sv/pmst_pkg.sv @@
// Package for the Prim spanning tree block: field widths, weight constants,
// request and status codes, and the sequencer state type.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pmst_pkg;

   localparam int unsigned MAX_NODES  = 16;
   localparam int unsigned NODE_SLOTS = 16;

   localparam int unsigned NODE_W   = 4;
   localparam int unsigned WEIGHT_W = 14;
   localparam int unsigned COST_W   = 18;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;

   localparam logic [WEIGHT_W-1:0] INF_WEIGHT = 14'd9999;
   localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = 14'd9998;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_RUN   = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_EDGE   = 2'd0,
      STS_SINGLE = 2'd1,
      STS_DISCON = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE2,
      ST_PASS,
      ST_END,
      ST_SINGLE
   } state_type;

endpackage

`default_nettype wire

@@ sv/pmst_adj_ram.sv @@
// Adjacency matrix storage: one write port and one read port with registered data.
// Depends on pmst_pkg for the weight width.
`default_nettype none

module pmst_adj_ram #(
   parameter int unsigned DEPTH = pmst_pkg::MAX_NODES * pmst_pkg::MAX_NODES,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [pmst_pkg::WEIGHT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [pmst_pkg::WEIGHT_W-1:0] rd_data
);

   logic [pmst_pkg::WEIGHT_W-1:0] mem_ff [DEPTH];
   logic [pmst_pkg::WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/prim_minimum_spanning_tree.sv @@
// Prim spanning tree over a stored adjacency matrix, driven by a small sequencer.
// Write edge: stores the weight at (a,b), then at (b,a). Clear: one matrix entry per cycle.
// Run over n nodes: up to n-1 scans of a matrix row, each followed by handing over its
// result; a stalled result holds the run, and a disconnected graph ends it early.
// Reset starts a clearing pass over all MAX_NODES*MAX_NODES entries; req_ready stays low until
// it is done. Requests are taken only while the sequencer is idle.
`default_nettype none

module prim_minimum_spanning_tree #(
   parameter int unsigned MAX_NODES = pmst_pkg::MAX_NODES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pmst_pkg::ACTION_W-1:0] req_action,
   input  wire logic [pmst_pkg::NODE_W-1:0]   req_node_a,
   input  wire logic [pmst_pkg::NODE_W-1:0]   req_node_b,
   input  wire logic [pmst_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [pmst_pkg::NODE_W-1:0]   rsp_tree_parent,
   output logic      [pmst_pkg::NODE_W-1:0]   rsp_tree_child,
   output logic      [pmst_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic      [pmst_pkg::COST_W-1:0]   rsp_total_cost,
   output logic      [pmst_pkg::STATUS_W-1:0] rsp_status,
   output logic                               rsp_last,
   input  wire logic                          csr_wr_en,
   input  wire logic [pmst_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int unsigned NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;
   localparam int unsigned DEPTH      = MAX_NODES * MAX_NODES;
   localparam int unsigned ADDR_W     = $clog2(DEPTH);
   localparam int unsigned NW = pmst_pkg::NODE_W;
   localparam int unsigned WW = pmst_pkg::WEIGHT_W;
   localparam int unsigned CW = pmst_pkg::COUNT_W;
   localparam int unsigned SW = pmst_pkg::COST_W;

   pmst_pkg::state_type state_ff, state_in;

   logic [CW-1:0]     node_count_ff;
   logic [CW-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic              pv_ff, pv_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     src_ff, src_in;
   logic              init_ff, init_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [WW-1:0]     min_ff, min_in;
   logic [NW-1:0]     mini_ff, mini_in;
   logic [NW-1:0]     minpar_ff, minpar_in;
   logic [SW-1:0]     cost_ff, cost_in;
   logic [NW-1:0]     wb_a_ff, wb_a_in;
   logic [NW-1:0]     wb_b_ff, wb_b_in;
   logic [WW-1:0]     wb_w_ff, wb_w_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]                 rsp_parent_ff, rsp_parent_in;
   logic [NW-1:0]                 rsp_child_ff, rsp_child_in;
   logic [WW-1:0]                 rsp_weight_ff, rsp_weight_in;
   logic [SW-1:0]                 rsp_cost_ff, rsp_cost_in;
   logic [pmst_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   logic          in_tree_ff [pmst_pkg::NODE_SLOTS];
   logic [WW-1:0] dist_ff    [pmst_pkg::NODE_SLOTS];
   logic [NW-1:0] par_ff     [pmst_pkg::NODE_SLOTS];

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WW-1:0]     mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [WW-1:0]     mem_rdata;

   logic          proc_we;
   logic          tree_set_we;
   logic [WW-1:0] edge_c;
   logic          cur_tree;
   logic [WW-1:0] cur_d;
   logic [NW-1:0] cur_p;
   logic [WW-1:0] new_d;
   logic [NW-1:0] new_p;
   logic [WW-1:0] sat_w;
   logic          in_range;
   logic [CW-1:0] run_n;
   logic          slot_free;
   logic          last_step;

   pmst_adj_ram #(
      .DEPTH(DEPTH)
   ) u_adj_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign req_ready = (state_ff == pmst_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == (n_ff - CW'(1)));

   // Working copy of the entry the matrix read returned in this cycle; also request checks.
   always_comb begin
      edge_c   = (mem_rdata == '0) ? pmst_pkg::INF_WEIGHT : mem_rdata;
      cur_tree = init_ff ? 1'b0 : in_tree_ff[idx_ff];
      cur_d    = init_ff ? edge_c : dist_ff[idx_ff];
      cur_p    = init_ff ? '0 : par_ff[idx_ff];
      new_d    = cur_d;
      new_p    = cur_p;
      if (!init_ff && !cur_tree && (cur_d > edge_c)) begin
         new_d = edge_c;
         new_p = src_ff;
      end
      sat_w    = (req_edge_weight > pmst_pkg::MAX_WEIGHT) ? pmst_pkg::MAX_WEIGHT
                                                          : req_edge_weight;
      in_range = (32'(req_node_a) < MAX_NODES) && (32'(req_node_b) < MAX_NODES);
      if (node_count_ff == '0) begin
         run_n = CW'(1);
      end else if (32'(node_count_ff) > NODE_LIMIT) begin
         run_n = CW'(NODE_LIMIT);
      end else begin
         run_n = node_count_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      clr_in      = clr_ff;
      iss_in      = iss_ff;
      pv_in       = 1'b0;
      idx_in      = idx_ff;
      src_in      = src_ff;
      init_in     = init_ff;
      step_in     = step_ff;
      min_in      = min_ff;
      mini_in     = mini_ff;
      minpar_in   = minpar_ff;
      cost_in     = cost_ff;
      wb_a_in     = wb_a_ff;
      wb_b_in     = wb_b_ff;
      wb_w_in     = wb_w_ff;
      mem_we      = 1'b0;
      mem_waddr   = clr_ff;
      mem_wdata   = '0;
      mem_raddr   = ADDR_W'(src_ff) * ADDR_W'(MAX_NODES) + ADDR_W'(iss_ff[NW-1:0]);
      proc_we     = 1'b0;
      tree_set_we = 1'b0;
      rsp_load      = 1'b0;
      rsp_parent_in = rsp_parent_ff;
      rsp_child_in  = rsp_child_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         pmst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = pmst_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         pmst_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  pmst_pkg::ACT_WRITE: begin
                     if (in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(req_node_a) * ADDR_W'(MAX_NODES)
                                    + ADDR_W'(req_node_b);
                        mem_wdata = sat_w;
                        wb_a_in   = req_node_a;
                        wb_b_in   = req_node_b;
                        wb_w_in   = sat_w;
                        state_in  = pmst_pkg::ST_WRITE2;
                     end
                  end
                  pmst_pkg::ACT_CLEAR: begin
                     clr_in   = '0;
                     state_in = pmst_pkg::ST_CLEAR;
                  end
                  pmst_pkg::ACT_RUN: begin
                     n_in = run_n;
                     if (run_n == CW'(1)) begin
                        state_in = pmst_pkg::ST_SINGLE;
                     end else begin
                        iss_in   = CW'(1);
                        src_in   = '0;
                        init_in  = 1'b1;
                        min_in   = pmst_pkg::INF_WEIGHT;
                        cost_in  = '0;
                        step_in  = CW'(1);
                        state_in = pmst_pkg::ST_PASS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pmst_pkg::ST_WRITE2: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(wb_b_ff) * ADDR_W'(MAX_NODES) + ADDR_W'(wb_a_ff);
            mem_wdata = wb_w_ff;
            state_in  = pmst_pkg::ST_IDLE;
         end
         pmst_pkg::ST_PASS: begin
            // Reads are issued one node ahead of the update that consumes them.
            if (iss_ff < n_ff) begin
               pv_in  = 1'b1;
               idx_in = iss_ff[NW-1:0];
               iss_in = iss_ff + CW'(1);
            end
            if (pv_ff) begin
               proc_we = 1'b1;
               if (!cur_tree && (new_d < min_ff)) begin
                  min_in    = new_d;
                  mini_in   = idx_ff;
                  minpar_in = new_p;
               end
            end
            if ((iss_ff == n_ff) && !pv_ff) begin
               state_in = pmst_pkg::ST_END;
            end
         end
         pmst_pkg::ST_END: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (min_ff == pmst_pkg::INF_WEIGHT) begin
                  rsp_parent_in = '0;
                  rsp_child_in  = '0;
                  rsp_weight_in = '0;
                  rsp_cost_in   = cost_ff;
                  rsp_status_in = pmst_pkg::STS_DISCON;
                  rsp_last_in   = 1'b1;
                  state_in      = pmst_pkg::ST_IDLE;
               end else begin
                  cost_in       = cost_ff + SW'(min_ff);
                  tree_set_we   = 1'b1;
                  rsp_parent_in = minpar_ff;
                  rsp_child_in  = mini_ff;
                  rsp_weight_in = min_ff;
                  rsp_cost_in   = cost_ff + SW'(min_ff);
                  rsp_status_in = pmst_pkg::STS_EDGE;
                  rsp_last_in   = last_step;
                  if (last_step) begin
                     state_in = pmst_pkg::ST_IDLE;
                  end else begin
                     src_in   = mini_ff;
                     iss_in   = CW'(1);
                     init_in  = 1'b0;
                     min_in   = pmst_pkg::INF_WEIGHT;
                     step_in  = step_ff + CW'(1);
                     state_in = pmst_pkg::ST_PASS;
                  end
               end
            end
         end
         pmst_pkg::ST_SINGLE: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_parent_in = '0;
               rsp_child_in  = '0;
               rsp_weight_in = '0;
               rsp_cost_in   = '0;
               rsp_status_in = pmst_pkg::STS_SINGLE;
               rsp_last_in   = 1'b1;
               state_in      = pmst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmst_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pmst_pkg::ST_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= CW'(1);
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      iss_ff    <= iss_in;
      idx_ff    <= idx_in;
      src_ff    <= src_in;
      init_ff   <= init_in;
      step_ff   <= step_in;
      min_ff    <= min_in;
      mini_ff   <= mini_in;
      minpar_ff <= minpar_in;
      cost_ff   <= cost_in;
      wb_a_ff   <= wb_a_in;
      wb_b_ff   <= wb_b_in;
      wb_w_ff   <= wb_w_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_child_ff  <= rsp_child_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (proc_we) begin
         dist_ff[idx_ff] <= new_d;
         par_ff[idx_ff]  <= new_p;
         if (init_ff) begin
            in_tree_ff[idx_ff] <= 1'b0;
         end
      end
      if (tree_set_we) begin
         in_tree_ff[mini_ff] <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tree_parent = rsp_parent_ff;
   assign rsp_tree_child  = rsp_child_ff;
   assign rsp_tree_weight = rsp_weight_ff;
   assign rsp_total_cost  = rsp_cost_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pmst_pkg::ST_PASS) |-> (iss_ff <= n_ff))
      else $error("scan counter ran past the node count");

   a_pipe_in_pass: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (state_ff == pmst_pkg::ST_PASS))
      else $error("pending matrix read outside a scan");

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == pmst_pkg::ACT_RUN)) |=> !req_ready)
      else $error("request taken while a run is in progress");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != pmst_pkg::STS_EDGE)) |-> rsp_last_ff)
      else $error("run-ending status without last flag");

   a_finite_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == pmst_pkg::STS_EDGE))
      |-> (rsp_weight_ff < pmst_pkg::INF_WEIGHT))
      else $error("tree edge reported with infinite weight");

endmodule

`default_nettype wire
